// ----- sv/laplacian_sharpen_3x3_unit_defines.svh -----
// Assertion macros shared by the sharpening filter RTL.
`ifndef LAPLACIAN_SHARPEN_3X3_UNIT_DEFINES_SVH
`define LAPLACIAN_SHARPEN_3X3_UNIT_DEFINES_SVH

// Same-cycle implication, ignored while in reset.
`define LSH_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, ignored while in reset.
`define LSH_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- sv/lsh_pkg.sv -----
// Shared types and constants of the 3x3 Laplacian sharpening filter.
package lsh_pkg;

  localparam int DEF_MAX_LINE_SAMPLES = 8192;
  localparam int DEF_MAX_CHANNELS     = 4;

  localparam int SAMPLE_W    = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int WIDTH_REG_W = 12;
  localparam int CHAN_REG_W  = 3;
  localparam int HGT_REG_W   = 13;
  localparam int ROW_W       = 12;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNELS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT   = 2'd2;

  localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [CHAN_REG_W-1:0]  CHAN_RESET   = 3'd3;
  localparam logic [HGT_REG_W-1:0]   HEIGHT_RESET = 13'd480;

  localparam logic [WIDTH_REG_W-1:0] WIDTH_MIN  = 12'd3;
  localparam logic [WIDTH_REG_W-1:0] WIDTH_MAX  = 12'd2048;
  localparam logic [HGT_REG_W-1:0]   HEIGHT_MIN = 13'd3;
  localparam logic [HGT_REG_W-1:0]   HEIGHT_MAX = 13'd4096;

  // neighbourhood of one cross stencil
  typedef struct packed {
    logic [SAMPLE_W-1:0] mid;
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    logic [SAMPLE_W-1:0] up;
    logic [SAMPLE_W-1:0] down;
  } taps_t;

endpackage

// ----- sv/lsh_ram.sv -----
// Simple dual-port RAM, one write and one registered read port.
module lsh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/lsh_kernel.sv -----
// Cross Laplacian kernel: 5*mid - neighbours, clamped, with border bypass.
module lsh_kernel (
  input  lsh_pkg::taps_t                 taps,
  input  logic                           on_border,
  output logic [lsh_pkg::SAMPLE_W-1:0]   result
);

  logic [10:0]        five_mid;
  logic [9:0]         nb_sum;
  logic signed [11:0] acc;

  always_comb begin
    five_mid = {1'b0, taps.mid, 2'b00} + {3'b000, taps.mid};
    nb_sum   = {2'b00, taps.left} + {2'b00, taps.right}
             + {2'b00, taps.up} + {2'b00, taps.down};
    acc      = signed'({1'b0, five_mid}) - signed'({2'b00, nb_sum});
    if (on_border) begin
      result = taps.mid;
    end else if (acc < 0) begin
      result = '0;
    end else if (acc > 12'sd255) begin
      result = '1;
    end else begin
      result = acc[7:0];
    end
  end

endmodule

// ----- sv/laplacian_sharpen_3x3_unit.sv -----
// Top level of the 3x3 cross Laplacian sharpening filter.
// An accepted word is registered in stage 1, then in the result register. One sample
// word per clock while the result side does not stall; the three line RAMs each see one
// read and one write per cycle; the kernel fits between RAM read and result register.
// Reset: clears counters, valids and the left-neighbour window, loads config defaults.
// Line stores are not cleared; each entry is written before a read whose value is used.
`include "laplacian_sharpen_3x3_unit_defines.svh"

module laplacian_sharpen_3x3_unit #(
  parameter int MAX_LINE_SAMPLES = lsh_pkg::DEF_MAX_LINE_SAMPLES,
  parameter int MAX_CHANNELS     = lsh_pkg::DEF_MAX_CHANNELS
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_write,
  input  logic [lsh_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [lsh_pkg::CFG_DATA_W-1:0]     cfg_data,
  // sample stream in
  input  logic                               pixel_valid,
  output logic                               pixel_stall,
  input  logic [lsh_pkg::SAMPLE_W-1:0]       sample,
  // result stream out
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic [lsh_pkg::SAMPLE_W-1:0]       value,
  output logic                               border,
  output logic                               end_of_line,
  output logic                               end_of_frame
);

  // AW addresses one line store, LW holds a line length up to the store depth.
  localparam int AW = (MAX_LINE_SAMPLES > 1) ? $clog2(MAX_LINE_SAMPLES) : 1;
  localparam int LW = $clog2(MAX_LINE_SAMPLES + 1);
  localparam int EW = (LW > lsh_pkg::WIDTH_REG_W) ? LW : lsh_pkg::WIDTH_REG_W;
  localparam int SW = lsh_pkg::SAMPLE_W;

  // per-channel-count line limits, worked out at elaboration
  localparam logic [LW-1:0] LIM1 = LW'(MAX_LINE_SAMPLES);
  localparam logic [LW-1:0] LIM2 = LW'(MAX_LINE_SAMPLES / 2);
  localparam logic [LW-1:0] LIM3 = LW'(MAX_LINE_SAMPLES / 3);
  localparam logic [LW-1:0] LIM4 = LW'(MAX_LINE_SAMPLES / 4);
  localparam logic [lsh_pkg::CHAN_REG_W-1:0] CH_MAX = lsh_pkg::CHAN_REG_W'(MAX_CHANNELS);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [lsh_pkg::WIDTH_REG_W-1:0] cfg_width;
  logic [lsh_pkg::CHAN_REG_W-1:0]  cfg_channels;
  logic [lsh_pkg::HGT_REG_W-1:0]   cfg_height;
  logic                            cfg_hit;

  assign cfg_hit = cfg_write && (cfg_index == lsh_pkg::REG_WIDTH ||
                                 cfg_index == lsh_pkg::REG_CHANNELS ||
                                 cfg_index == lsh_pkg::REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width    <= lsh_pkg::WIDTH_RESET;
      cfg_channels <= lsh_pkg::CHAN_RESET;
      cfg_height   <= lsh_pkg::HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        lsh_pkg::REG_WIDTH:    cfg_width    <= cfg_data[lsh_pkg::WIDTH_REG_W-1:0];
        lsh_pkg::REG_CHANNELS: cfg_channels <= cfg_data[lsh_pkg::CHAN_REG_W-1:0];
        lsh_pkg::REG_HEIGHT:   cfg_height   <= cfg_data[lsh_pkg::HGT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Effective geometry: saturate out-of-range settings
  // ---------------------------------------------------------------------------
  logic [lsh_pkg::CHAN_REG_W-1:0]  ch_eff;
  logic [lsh_pkg::WIDTH_REG_W-1:0] w_clamp;
  logic [LW-1:0]                   line_lim;
  logic [EW-1:0]                   w_eff;
  logic [EW+lsh_pkg::CHAN_REG_W-1:0] line_prod;
  logic [LW-1:0]                   line_len;
  logic [LW-1:0]                   ch_ext;
  logic [lsh_pkg::HGT_REG_W-1:0]   height;

  always_comb begin
    if (cfg_channels == '0) begin
      ch_eff = 3'd1;
    end else if (cfg_channels > CH_MAX) begin
      ch_eff = CH_MAX;
    end else begin
      ch_eff = cfg_channels;
    end

    if (cfg_width < lsh_pkg::WIDTH_MIN) begin
      w_clamp = lsh_pkg::WIDTH_MIN;
    end else if (cfg_width > lsh_pkg::WIDTH_MAX) begin
      w_clamp = lsh_pkg::WIDTH_MAX;
    end else begin
      w_clamp = cfg_width;
    end

    case (ch_eff)
      3'd1:    line_lim = LIM1;
      3'd2:    line_lim = LIM2;
      3'd3:    line_lim = LIM3;
      default: line_lim = LIM4;
    endcase

    if (EW'(w_clamp) > EW'(line_lim)) begin
      w_eff = EW'(line_lim);
    end else begin
      w_eff = EW'(w_clamp);
    end
    line_prod = w_eff * ch_eff;
    line_len  = line_prod[LW-1:0];
    ch_ext    = LW'(ch_eff);

    if (cfg_height < lsh_pkg::HEIGHT_MIN) begin
      height = lsh_pkg::HEIGHT_MIN;
    end else if (cfg_height > lsh_pkg::HEIGHT_MAX) begin
      height = lsh_pkg::HEIGHT_MAX;
    end else begin
      height = cfg_height;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake and pipeline control
  //   stage 0: accept word, issue line store reads at col and col+channels
  //   stage 1: read data present, kernel, line store write-back
  //   result register: holds the word while the consumer stalls
  // ---------------------------------------------------------------------------
  logic          pix_acc;
  logic          out_ready;
  logic          s1_go;
  logic          s1_valid;
  logic [SW-1:0] s1_sample;
  logic [AW-1:0] s1_col;
  logic          s1_border;
  logic          s1_eol;
  logic          s1_eof;
  logic          s1_emit;

  assign out_ready   = !result_valid || !result_stall;
  assign s1_go       = s1_valid && (!s1_emit || out_ready);
  assign pixel_stall = s1_valid && !s1_go;
  assign pix_acc     = pixel_valid && !pixel_stall;

  // ---------------------------------------------------------------------------
  // Raster position counters
  // ---------------------------------------------------------------------------
  logic [AW-1:0]          col;
  logic [lsh_pkg::ROW_W-1:0] row;
  logic [LW-1:0]          col_ext;
  logic [LW-1:0]          right_ext;
  logic                   at_eol;
  logic                   at_last_row;
  logic                   at_border;

  always_comb begin
    col_ext     = LW'(col);
    right_ext   = col_ext + ch_ext;
    at_eol      = (col_ext == line_len - 1'b1);
    at_last_row = ({1'b0, row} == height - 1'b1);
    // line_len is at least three pixels, so line_len - channels never wraps
    at_border   = (col_ext < ch_ext) || (col_ext >= line_len - ch_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cfg_hit) begin
      // any register write restarts the frame
      col <= '0;
      row <= '0;
    end else if (pix_acc) begin
      if (at_eol) begin
        col <= '0;
        row <= at_last_row ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (pix_acc) begin
      s1_sample <= sample;
      s1_col    <= col;
      s1_border <= at_border;
      s1_eol    <= at_eol;
      s1_eof    <= at_eol && at_last_row;
      s1_emit   <= (row >= lsh_pkg::ROW_W'(2));
    end
  end

  // ---------------------------------------------------------------------------
  // Line stores. The previous row is kept twice so that the centre and the
  // right neighbour come out in the same cycle. Writes land at s1_col, which
  // never equals a read address of the word being accepted.
  // ---------------------------------------------------------------------------
  logic [SW-1:0] up_q;
  logic [SW-1:0] mid_q;
  logic [SW-1:0] right_q;

  lsh_ram #(.WIDTH(SW), .DEPTH(MAX_LINE_SAMPLES)) u_older (
    .clk     (clk),
    .wr_en   (s1_go),
    .wr_addr (s1_col),
    .wr_data (mid_q),
    .rd_en   (pix_acc),
    .rd_addr (col),
    .rd_data (up_q)
  );

  lsh_ram #(.WIDTH(SW), .DEPTH(MAX_LINE_SAMPLES)) u_newer_mid (
    .clk     (clk),
    .wr_en   (s1_go),
    .wr_addr (s1_col),
    .wr_data (s1_sample),
    .rd_en   (pix_acc),
    .rd_addr (col),
    .rd_data (mid_q)
  );

  // right neighbour; the address may fall past the line only in the border,
  // where the value is not used
  lsh_ram #(.WIDTH(SW), .DEPTH(MAX_LINE_SAMPLES)) u_newer_right (
    .clk     (clk),
    .wr_en   (s1_go),
    .wr_addr (s1_col),
    .wr_data (s1_sample),
    .rd_en   (pix_acc),
    .rd_addr (right_ext[AW-1:0]),
    .rd_data (right_q)
  );

  // ---------------------------------------------------------------------------
  // Left neighbour window: the last MAX_CHANNELS centre samples of the row
  // above; the one `channels` words back sits at win[channels-1].
  // ---------------------------------------------------------------------------
  logic [SW-1:0] win [MAX_CHANNELS];
  logic [SW-1:0] left_tap;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        win[i] <= '0;
      end
    end else if (s1_go) begin
      win[0] <= mid_q;
      for (int i = 1; i < MAX_CHANNELS; i++) begin
        win[i] <= win[i-1];
      end
    end
  end

  always_comb begin
    left_tap = win[0];
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      if (ch_eff == lsh_pkg::CHAN_REG_W'(i + 1)) begin
        left_tap = win[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Kernel and result register
  // ---------------------------------------------------------------------------
  lsh_pkg::taps_t taps;
  logic [SW-1:0]  kern_value;

  always_comb begin
    taps.mid   = mid_q;
    taps.left  = left_tap;
    taps.right = right_q;
    taps.up    = up_q;
    taps.down  = s1_sample;
  end

  lsh_kernel u_kernel (
    .taps      (taps),
    .on_border (s1_border),
    .result    (kern_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_go && s1_emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emit) begin
      value        <= kern_value;
      border       <= s1_border;
      end_of_line  <= s1_eol;
      end_of_frame <= s1_eof;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `LSH_ASSERT_IMP(a_stall_needs_busy, clk, rst, pixel_stall, s1_valid)
  `LSH_ASSERT_IMP(a_eof_on_eol, clk, rst, result_valid && end_of_frame, end_of_line)
  `LSH_ASSERT_IMP(a_eol_is_border, clk, rst, result_valid && end_of_line, border)
  `LSH_ASSERT_NXT(a_stage_drains, clk, rst, s1_go && !pix_acc, !s1_valid)
  `LSH_ASSERT_IMP(a_col_in_line, clk, rst, pix_acc, col_ext < line_len)

endmodule

// ----- tb/laplacian_sharpen_3x3_unit_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the sharpening filter: mirrors the cross stencil and checks each result word.
module laplacian_sharpen_3x3_unit_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [lsh_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lsh_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            pixel_valid,
  input  logic                            pixel_stall,
  input  logic [lsh_pkg::SAMPLE_W-1:0]    sample,
  input  logic                            result_valid,
  input  logic                            result_stall,
  input  logic [lsh_pkg::SAMPLE_W-1:0]    value,
  input  logic                            border,
  input  logic                            end_of_line,
  input  logic                            end_of_frame,
  output int unsigned                     words_due,
  output int unsigned                     mismatches
);
  import lsh_pkg::*;

  localparam int LINE_DEPTH = DEF_MAX_LINE_SAMPLES;
  localparam int WIN_TAPS   = 2 * DEF_MAX_CHANNELS + 1;
  localparam int PIXEL_TOP  = (1 << SAMPLE_W) - 1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                border;
    logic                eol;
    logic                eof;
  } sharp_word_t;

  logic [WIDTH_REG_W-1:0] width_reg;
  logic [CHAN_REG_W-1:0]  chan_reg;
  logic [HGT_REG_W-1:0]   height_reg;
  logic [SAMPLE_W-1:0]    older_row [LINE_DEPTH];
  logic [SAMPLE_W-1:0]    newer_row [LINE_DEPTH];
  logic [SAMPLE_W-1:0]    left_taps [WIN_TAPS];
  int unsigned            col_pos;
  int unsigned            row_pos;
  int unsigned            miss_total;
  sharp_word_t            sharpened_q [$];

  // One sample in; result for the same position one row up, once row 2 is reached.
  task automatic sharpen_step(input logic [SAMPLE_W-1:0] s, output bit emitted,
                              output sharp_word_t w);
    int unsigned ch, px, line, rows, c, r;
    int i, acc;
    logic [SAMPLE_W-1:0] up, mid, right, left;
    ch = (chan_reg == 0) ? 1 : (chan_reg > DEF_MAX_CHANNELS) ? DEF_MAX_CHANNELS : chan_reg;
    px = (width_reg > WIDTH_MAX) ? WIDTH_MAX : width_reg;
    if (px < WIDTH_MIN) px = WIDTH_MIN;
    if (px > LINE_DEPTH / ch) px = LINE_DEPTH / ch;
    line = px * ch;
    rows = (height_reg < HEIGHT_MIN) ? HEIGHT_MIN :
           (height_reg > HEIGHT_MAX) ? HEIGHT_MAX : height_reg;
    c = (col_pos >= line) ? line - 1 : col_pos;
    r = (row_pos >= rows) ? rows - 1 : row_pos;

    up    = older_row[c];
    mid   = newer_row[c];
    right = (c + ch < line) ? newer_row[c + ch] : '0;
    for (i = WIN_TAPS - 1; i > 0; i--) left_taps[i] = left_taps[i-1];
    left_taps[0] = mid;
    left = left_taps[ch];
    older_row[c] = mid;
    newer_row[c] = s;

    emitted  = (r >= 2);
    w.border = (c < ch) || (c >= line - ch);
    w.eol    = (c == line - 1);
    w.eof    = w.eol && (r == rows - 1);
    acc = 5 * int'(mid) - (int'(left) + int'(right) + int'(up) + int'(s));
    if (w.border)           w.value = mid;
    else if (acc < 0)       w.value = '0;
    else if (acc > PIXEL_TOP) w.value = '1;
    else                    w.value = acc[SAMPLE_W-1:0];

    c++;
    if (c >= line) begin
      c = 0;
      r++;
      if (r >= rows) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  function automatic int field_diff(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t %s: expected %0d, got %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    sharp_word_t want;
    sharp_word_t fresh;
    bit          emitted;
    int          i;
    if (rst) begin
      width_reg  = WIDTH_RESET;
      chan_reg   = CHAN_RESET;
      height_reg = HEIGHT_RESET;
      for (i = 0; i < LINE_DEPTH; i++) begin
        older_row[i] = '0;
        newer_row[i] = '0;
      end
      for (i = 0; i < WIN_TAPS; i++) left_taps[i] = '0;
      col_pos    = 0;
      row_pos    = 0;
      miss_total = 0;
      sharpened_q.delete();
    end else begin
      // any write to a real register restarts the frame; the spare index is ignored
      if (cfg_write) begin
        case (cfg_index)
          REG_WIDTH: begin
            width_reg = cfg_data[WIDTH_REG_W-1:0];
            col_pos = 0;
            row_pos = 0;
          end
          REG_CHANNELS: begin
            chan_reg = cfg_data[CHAN_REG_W-1:0];
            col_pos = 0;
            row_pos = 0;
          end
          REG_HEIGHT: begin
            height_reg = cfg_data[HGT_REG_W-1:0];
            col_pos = 0;
            row_pos = 0;
          end
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        if (sharpened_q.size() == 0) begin
          $display("%0t unexpected word: value %0d border %0b eol %0b eof %0b",
                   $time, value, border, end_of_line, end_of_frame);
          miss_total++;
        end else begin
          want = sharpened_q.pop_front();
          miss_total += field_diff("value", want.value, value)
                      + field_diff("border", want.border, border)
                      + field_diff("end_of_line", want.eol, end_of_line)
                      + field_diff("end_of_frame", want.eof, end_of_frame);
        end
      end
      if (pixel_valid && !pixel_stall) begin
        sharpen_step(sample, emitted, fresh);
        if (emitted) sharpened_q.push_back(fresh);
      end
    end
    words_due  <= sharpened_q.size();
    mismatches <= miss_total;
  end

endmodule

// ----- tb/laplacian_sharpen_3x3_unit_tb.sv -----
`timescale 1ns / 1ps
// Top testbench for the sharpening filter: clock, reset, stimulus phases and final verdict.
module laplacian_sharpen_3x3_unit_tb;
  import lsh_pkg::*;

  // index 3 is unmapped; a write there must not touch the frame position
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
  localparam int RUN_LIMIT_NS   = 40_000_000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RANDOM_WORDS   = 700;
  localparam int DIRECTED_WORDS = 27;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   cfg_write    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;
  logic                   pixel_valid  = 1'b0;
  logic                   pixel_stall;
  logic [SAMPLE_W-1:0]    sample       = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic [SAMPLE_W-1:0]    value;
  logic                   border;
  logic                   end_of_line;
  logic                   end_of_frame;
  int unsigned            words_due;
  int unsigned            mismatches;

  // idle percentages for the current phase
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;

  // Three 3x3 single-channel frames, row by row:
  //  bright centre on black -> clamps high
  //  dark centre on white   -> clamps low
  //  mid-range values       -> 5*100 - (90+110+95+105) = 100, no clamp
  logic [SAMPLE_W-1:0] directed_words [0:DIRECTED_WORDS-1] = '{
    8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd0,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255,
    8'd7,   8'd95,  8'd9,   8'd90,  8'd100, 8'd110, 8'd4,   8'd105, 8'd6
  };

  laplacian_sharpen_3x3_unit u_dut (.*);

  laplacian_sharpen_3x3_unit_checker u_check (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver side: random stall each cycle at the phase's rate.
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  // Rotate through: free-running, sender idle, receiver stalling, both.
  task automatic set_idling(input int unsigned phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 76; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 76; end
      default: begin send_idle_pct = 21; stall_pct = 21; end
    endcase
  endtask

  // Bias toward the rails so both clamps fire often.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return SAMPLE_W'($urandom_range(255));
    endcase
  endfunction

  // Offer one word; valid stays up until the edge that takes it.
  task automatic send_word(input logic [SAMPLE_W-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    sample      <= s;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
  endtask

  task automatic run_words(input int unsigned n);
    repeat (n) send_word(pick_sample());
  endtask

  // Drop valid, wait for every expected word, then let the pipe run dry
  // (rows 0 and 1 leave words in flight with no result).
  task automatic settle();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Back-to-back register writes; junk above the width and channels fields must be masked.
  task automatic configure(input logic [WIDTH_REG_W-1:0] px, input logic [CHAN_REG_W-1:0] ch,
                           input logic [HGT_REG_W-1:0] rows);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    cfg_write <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_data  <= {junk[CFG_DATA_W-1:WIDTH_REG_W], px};
    @(posedge clk);
    cfg_index <= REG_CHANNELS;
    cfg_data  <= {junk[CFG_DATA_W-1:CHAN_REG_W], ch};
    @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data  <= rows;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // One setting, n random words; optionally an unmapped write mid-frame.
  task automatic run_phase(input int unsigned phase, input logic [WIDTH_REG_W-1:0] px,
                           input logic [CHAN_REG_W-1:0] ch, input logic [HGT_REG_W-1:0] rows,
                           input int unsigned n, input bit spare_write);
    set_idling(phase);
    configure(px, ch, rows);
    if (spare_write) begin
      run_words(n / 2);
      settle();
      cfg_write <= 1'b1;
      cfg_index <= REG_SPARE;
      cfg_data  <= CFG_DATA_W'($urandom);
      @(posedge clk);
      cfg_write <= 1'b0;
      run_words(n - n / 2);
    end else begin
      run_words(n);
    end
    settle();
  endtask

  initial begin
    int unsigned random_words, n, phase, i;
    logic [WIDTH_REG_W-1:0] px;
    logic [HGT_REG_W-1:0]   rows;
    random_words = 0;
    phase = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset settings (640 px x 3 ch): part of the first row, so no results are due.
    set_idling(phase);
    run_words(200);
    settle();
    phase++;

    // Directed: smallest frame, both clamps, a plain interior value, frame wrap.
    set_idling(phase);
    configure(WIDTH_MIN, 3'd1, HEIGHT_MIN);
    for (i = 0; i < DIRECTED_WORDS; i++) send_word(directed_words[i]);
    settle();
    phase++;

    // Register extremes. All-zero writes saturate up to 3 x 1 x 3.
    run_phase(phase, '0, '0, '0, 60, 1'b0);
    phase++;
    // All-ones width and channels saturate to 2048 px x 4 ch; first row only.
    run_phase(phase, '1, '1, HEIGHT_MIN, 120, 1'b0);
    phase++;
    // Tallest frame (all-ones height saturates to 4096) on the narrowest line.
    run_phase(phase, 12'd1, 3'd1, '1, 90, 1'b0);
    phase++;
    // Channels above the maximum saturate to 4; height 2 saturates to 3.
    run_phase(phase, 12'd2, 3'd5, 13'd2, 100, 1'b0);
    phase++;

    // Random small settings and word counts, sometimes a spare-index write.
    while (random_words < RANDOM_WORDS) begin
      n    = $urandom_range(20, 200);
      px   = ($urandom_range(4) == 0) ? WIDTH_REG_W'($urandom_range(2))
                                      : WIDTH_REG_W'($urandom_range(3, 24));
      rows = ($urandom_range(4) == 0) ? HGT_REG_W'($urandom_range(2))
                                      : HGT_REG_W'($urandom_range(3, 8));
      run_phase(phase, px, CHAN_REG_W'($urandom_range(7)), rows, n,
                $urandom_range(3) == 0);
      phase++;
      random_words += n;
    end

    if (mismatches == 0) begin
      $display("[laplacian_sharpen_3x3_unit] OK");
    end else begin
      $display("[laplacian_sharpen_3x3_unit] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(RUN_LIMIT_NS);
    $display("[laplacian_sharpen_3x3_unit] ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/lsh_pkg.sv
sv/lsh_ram.sv
sv/lsh_kernel.sv
sv/laplacian_sharpen_3x3_unit.sv
tb/laplacian_sharpen_3x3_unit_checker.sv
tb/laplacian_sharpen_3x3_unit_tb.sv
